// ===== rtl/rfts_pkg.sv =====
// Shared types, constants and helpers for the repeat-frame transmit sequencer.
// Used by every module under rtl; depends on nothing.
package rfts_pkg;

  localparam int BUFFER_BYTES   = 32;
  localparam int HOP_SLOTS      = 4;
  localparam int HOP_ENTRIES    = 4;
  localparam int HOP_W          = 2;
  localparam int BYTE_W         = 8;
  localparam int CH_W           = 7;
  localparam int MS_W           = 8;
  localparam int BMS_W          = 5;
  localparam int BCNT_W         = 4;
  localparam int OP_W           = 2;
  localparam int PADDR_W        = 5;
  localparam int PDATA_W        = 32;
  localparam int SECOND_SEND_MS = 60;
  localparam int RETIRE_MS      = 180;

  typedef enum logic [OP_W-1:0] {
    OP_BYTE = 2'd0,
    OP_TICK = 2'd1,
    OP_PAIR = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_FIRST  = 2'd1,
    PH_SECOND = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    REG_BURST_MODE   = 3'd0,
    REG_HOP_A        = 3'd1,
    REG_HOP_B        = 3'd2,
    REG_HOP_C        = 3'd3,
    REG_HOP_D        = 3'd4,
    REG_FIXED_CH     = 3'd5,
    REG_BURST_COUNT  = 3'd6,
    REG_BURST_PERIOD = 3'd7
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCHED,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_DBL_RD,
    ST_DBL_HI,
    ST_DBL_LO,
    ST_BURST_RD,
    ST_BURST_OUT
  } state_e;

  typedef struct packed {
    logic                            burst_mode;
    logic [HOP_SLOTS-1:0][CH_W-1:0]  hop_channel;
    logic [CH_W-1:0]                 fixed_channel;
    logic [BCNT_W-1:0]               burst_count;
    logic [BMS_W-1:0]                burst_period;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic [CH_W-1:0]   channel;
    logic              pair;
  } emit_t;

  function automatic logic [BYTE_W-1:0] double_nibble(input logic [3:0] n);
    return {n[3], n[3], n[2], n[2], n[1], n[1], n[0], n[0]};
  endfunction

endpackage

// ===== rtl/repeat_frame_tx_sequencer_top.sv =====
// Repeat-frame transmit sequencer top: config port, core, output register.
// A request passes an accept and a schedule step; scheduling repeats when a buffer retires.
// A bit-doubling send reads each payload byte and issues its doubled nibbles, high first;
// a burst-mode copy reads and writes each byte; a burst send reads each frame byte from RAM.
// Results leave through an output register that loads when empty or when its result is taken.
// Reset clears all control state and loads register defaults; RAM contents stay undefined.
module repeat_frame_tx_sequencer_top #(
  parameter int BUFFER_BYTES = rfts_pkg::BUFFER_BYTES
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [rfts_pkg::OP_W-1:0]    operation_i,
  input  logic [rfts_pkg::BYTE_W-1:0]  payload_byte_i,
  input  logic                         payload_end_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [rfts_pkg::BYTE_W-1:0]  tx_byte_o,
  output logic                         tx_end_o,
  output logic [rfts_pkg::CH_W-1:0]    tx_channel_o,
  output logic                         use_pair_address_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rfts_pkg::PADDR_W-1:0] paddr,
  input  logic [rfts_pkg::PDATA_W-1:0] pwdata,
  output logic [rfts_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  rfts_pkg::cfg_t  cfg;
  rfts_pkg::emit_t emit;
  logic            emit_ready;

  logic                        out_valid_q, out_valid_d;
  logic [rfts_pkg::BYTE_W-1:0] tx_byte_q;
  logic                        tx_end_q;
  logic [rfts_pkg::CH_W-1:0]   tx_channel_q;
  logic                        pair_q;

  rfts_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rfts_core #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .payload_byte_i (payload_byte_i),
    .payload_end_i  (payload_end_i),
    .cfg_i          (cfg),
    .emit_ready_i   (emit_ready),
    .emit_o         (emit)
  );

  assign emit_ready  = !out_valid_q || !out_stall_i;
  assign out_valid_d = emit_ready ? emit.valid : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_ready && emit.valid) begin
      tx_byte_q    <= emit.data;
      tx_end_q     <= emit.last;
      tx_channel_q <= emit.channel;
      pair_q       <= emit.pair;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign tx_byte_o          = tx_byte_q;
  assign tx_end_o           = tx_end_q;
  assign tx_channel_o       = tx_channel_q;
  assign use_pair_address_o = pair_q;

  a_idle_no_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !emit.valid)
    else $error("core issued a result while taking requests");

  a_accept_stalls : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("core took a request without a scheduling cycle");

  a_emit_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit.valid && !emit_ready |=> emit.valid && $stable(emit.data) && $stable(emit.last))
    else $error("blocked result changed before the output register took it");

endmodule

// ===== rtl/rfts_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; default sizes come from rfts_pkg.
module rfts_ram #(
  parameter int WIDTH = rfts_pkg::BYTE_W,
  parameter int DEPTH = 2 * rfts_pkg::BUFFER_BYTES,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/rfts_cfg.sv =====
// APB-style configuration register file for the transmit sequencer.
// Depends on rfts_pkg for register codes and the cfg_t bundle.
module rfts_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rfts_pkg::PADDR_W-1:0] paddr,
  input  logic [rfts_pkg::PDATA_W-1:0] pwdata,
  output logic [rfts_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output rfts_pkg::cfg_t               cfg_o
);

  rfts_pkg::cfg_t cfg_q, cfg_d;
  rfts_pkg::reg_e sel;
  logic           wr;

  assign sel    = rfts_pkg::reg_e'(paddr[rfts_pkg::PADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      case (sel)
        rfts_pkg::REG_BURST_MODE:   cfg_d.burst_mode     = pwdata[0];
        rfts_pkg::REG_HOP_A:        cfg_d.hop_channel[0] = pwdata[rfts_pkg::CH_W-1:0];
        rfts_pkg::REG_HOP_B:        cfg_d.hop_channel[1] = pwdata[rfts_pkg::CH_W-1:0];
        rfts_pkg::REG_HOP_C:        cfg_d.hop_channel[2] = pwdata[rfts_pkg::CH_W-1:0];
        rfts_pkg::REG_HOP_D:        cfg_d.hop_channel[3] = pwdata[rfts_pkg::CH_W-1:0];
        rfts_pkg::REG_FIXED_CH:     cfg_d.fixed_channel  = pwdata[rfts_pkg::CH_W-1:0];
        rfts_pkg::REG_BURST_COUNT:  cfg_d.burst_count    = pwdata[rfts_pkg::BCNT_W-1:0];
        rfts_pkg::REG_BURST_PERIOD: cfg_d.burst_period   = pwdata[rfts_pkg::BMS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      rfts_pkg::REG_BURST_MODE:   prdata = rfts_pkg::PDATA_W'(cfg_q.burst_mode);
      rfts_pkg::REG_HOP_A:        prdata = rfts_pkg::PDATA_W'(cfg_q.hop_channel[0]);
      rfts_pkg::REG_HOP_B:        prdata = rfts_pkg::PDATA_W'(cfg_q.hop_channel[1]);
      rfts_pkg::REG_HOP_C:        prdata = rfts_pkg::PDATA_W'(cfg_q.hop_channel[2]);
      rfts_pkg::REG_HOP_D:        prdata = rfts_pkg::PDATA_W'(cfg_q.hop_channel[3]);
      rfts_pkg::REG_FIXED_CH:     prdata = rfts_pkg::PDATA_W'(cfg_q.fixed_channel);
      rfts_pkg::REG_BURST_COUNT:  prdata = rfts_pkg::PDATA_W'(cfg_q.burst_count);
      rfts_pkg::REG_BURST_PERIOD: prdata = rfts_pkg::PDATA_W'(cfg_q.burst_period);
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.burst_mode    <= 1'b1;
      cfg_q.hop_channel   <= '0;
      cfg_q.fixed_channel <= '0;
      cfg_q.burst_count   <= rfts_pkg::BCNT_W'(3);
      cfg_q.burst_period  <= rfts_pkg::BMS_W'(6);
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== rtl/rfts_core.sv =====
// Sequencer core: ping-pong payload buffers, send scheduler, burst timer.
// Depends on rfts_pkg; holds payload and frame bytes in two rfts_ram instances.
module rfts_core #(
  parameter int BUFFER_BYTES = rfts_pkg::BUFFER_BYTES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [rfts_pkg::OP_W-1:0]   operation_i,
  input  logic [rfts_pkg::BYTE_W-1:0] payload_byte_i,
  input  logic                        payload_end_i,
  input  rfts_pkg::cfg_t              cfg_i,
  input  logic                        emit_ready_i,
  output rfts_pkg::emit_t             emit_o
);

  localparam int CNT_W     = $clog2(BUFFER_BYTES + 1);
  localparam int FL_W      = $clog2(BUFFER_BYTES + 2);
  localparam int BUF_DEPTH = 2 * BUFFER_BYTES;
  localparam int BA_W      = $clog2(BUF_DEPTH);
  localparam int FRM_DEPTH = BUFFER_BYTES + 1;
  localparam int FA_W      = $clog2(FRM_DEPTH);

  localparam int MS_W   = rfts_pkg::MS_W;
  localparam int BMS_W  = rfts_pkg::BMS_W;
  localparam int BCNT_W = rfts_pkg::BCNT_W;
  localparam int HOP_W  = rfts_pkg::HOP_W;
  localparam int BYTE_W = rfts_pkg::BYTE_W;
  localparam int CH_W   = rfts_pkg::CH_W;

  rfts_pkg::state_e state_q, state_d;
  rfts_pkg::phase_e phase_q, phase_d;
  rfts_pkg::op_e    op;

  logic [CNT_W-1:0]  len_q [2];
  logic [CNT_W-1:0]  len_d [2];
  logic              active_q, active_d;
  logic              wbuf_q, wbuf_d;
  logic [CNT_W-1:0]  wcnt_q, wcnt_d;
  logic [MS_W-1:0]   ms_q, ms_d;
  logic [FL_W-1:0]   flen_q, flen_d;
  logic [BYTE_W-1:0] seq_q, seq_d;
  logic              last_q, last_d;
  logic              run_q, run_d;
  logic [BCNT_W-1:0] sent_q, sent_d;
  logic [BMS_W-1:0]  bms_q, bms_d;
  logic [HOP_W-1:0]  hop_q, hop_d;
  logic              pair_q, pair_d;
  logic [FL_W-1:0]   cnt_q, cnt_d;
  logic [CH_W-1:0]   ch_q, ch_d;

  logic [CNT_W-1:0]  cur_len;
  logic              send_now, retire_now;
  logic              tick_live, fire;
  logic [BMS_W-1:0]  bms_inc;
  logic [BCNT_W-1:0] sent_inc;
  logic [FL_W-1:0]   cnt_nx;
  logic              cnt_last_len, cnt_last_flen;
  logic              wb_sel, room;
  logic [CNT_W-1:0]  wcnt_inc;

  logic              buf_we, buf_re;
  logic [BA_W-1:0]   buf_waddr, buf_raddr;
  logic [BYTE_W-1:0] buf_rdata;
  logic              frm_we, frm_re;
  logic [FA_W-1:0]   frm_waddr, frm_raddr;
  logic [BYTE_W-1:0] frm_wdata, frm_rdata;

  assign op         = rfts_pkg::op_e'(operation_i);
  assign in_stall_o = (state_q != rfts_pkg::ST_IDLE);

  assign cur_len    = len_q[active_q];
  assign send_now   = (cur_len != '0) &&
                      ((phase_q == rfts_pkg::PH_IDLE) ||
                       ((phase_q == rfts_pkg::PH_FIRST) &&
                        (ms_q > MS_W'(rfts_pkg::SECOND_SEND_MS))));
  assign retire_now = (cur_len != '0) && (phase_q == rfts_pkg::PH_SECOND) &&
                      (ms_q > MS_W'(rfts_pkg::RETIRE_MS));

  assign tick_live  = run_q && cfg_i.burst_mode;
  assign bms_inc    = bms_q + BMS_W'(1);
  assign fire       = tick_live &&
                      ((cfg_i.burst_period == '0) || (bms_inc >= cfg_i.burst_period));
  assign sent_inc   = sent_q + BCNT_W'(1);

  assign cnt_nx        = cnt_q + FL_W'(1);
  assign cnt_last_len  = (cnt_nx == FL_W'(cur_len));
  assign cnt_last_flen = (cnt_nx == flen_q);

  assign wb_sel   = (wcnt_q == '0) ? ((phase_q == rfts_pkg::PH_IDLE) ? active_q : ~active_q)
                                   : wbuf_q;
  assign room     = (wcnt_q < CNT_W'(BUFFER_BYTES));
  assign wcnt_inc = room ? (wcnt_q + CNT_W'(1)) : wcnt_q;

  assign buf_waddr = BA_W'(wcnt_q) + (wb_sel ? BA_W'(BUFFER_BYTES) : '0);
  assign buf_raddr = BA_W'(cnt_q) + (active_q ? BA_W'(BUFFER_BYTES) : '0);
  assign frm_raddr = FA_W'(cnt_q);

  rfts_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUF_DEPTH)
  ) u_buf_ram (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (buf_waddr),
    .wdata_i (payload_byte_i),
    .re_i    (buf_re),
    .raddr_i (buf_raddr),
    .rdata_o (buf_rdata)
  );

  rfts_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (FRM_DEPTH)
  ) u_frm_ram (
    .clk_i   (clk_i),
    .we_i    (frm_we),
    .waddr_i (frm_waddr),
    .wdata_i (frm_wdata),
    .re_i    (frm_re),
    .raddr_i (frm_raddr),
    .rdata_o (frm_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      rfts_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if ((op == rfts_pkg::OP_TICK) && fire && (flen_q != '0)) begin
            state_d = rfts_pkg::ST_BURST_RD;
          end else begin
            state_d = rfts_pkg::ST_SCHED;
          end
        end
      end
      rfts_pkg::ST_SCHED: begin
        if (send_now) begin
          state_d = cfg_i.burst_mode ? rfts_pkg::ST_COPY_RD : rfts_pkg::ST_DBL_RD;
        end else if (retire_now) begin
          state_d = rfts_pkg::ST_SCHED;
        end else begin
          state_d = rfts_pkg::ST_IDLE;
        end
      end
      rfts_pkg::ST_COPY_RD: state_d = rfts_pkg::ST_COPY_WR;
      rfts_pkg::ST_COPY_WR: begin
        state_d = cnt_last_len ? rfts_pkg::ST_IDLE : rfts_pkg::ST_COPY_RD;
      end
      rfts_pkg::ST_DBL_RD: state_d = rfts_pkg::ST_DBL_HI;
      rfts_pkg::ST_DBL_HI: begin
        if (emit_ready_i) begin
          state_d = rfts_pkg::ST_DBL_LO;
        end
      end
      rfts_pkg::ST_DBL_LO: begin
        if (emit_ready_i) begin
          state_d = cnt_last_len ? rfts_pkg::ST_IDLE : rfts_pkg::ST_DBL_RD;
        end
      end
      rfts_pkg::ST_BURST_RD: state_d = rfts_pkg::ST_BURST_OUT;
      rfts_pkg::ST_BURST_OUT: begin
        if (emit_ready_i) begin
          state_d = cnt_last_flen ? rfts_pkg::ST_SCHED : rfts_pkg::ST_BURST_RD;
        end
      end
      default: state_d = rfts_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    len_d     = len_q;
    active_d  = active_q;
    wbuf_d    = wbuf_q;
    wcnt_d    = wcnt_q;
    phase_d   = phase_q;
    ms_d      = ms_q;
    flen_d    = flen_q;
    seq_d     = seq_q;
    last_d    = last_q;
    run_d     = run_q;
    sent_d    = sent_q;
    bms_d     = bms_q;
    hop_d     = hop_q;
    pair_d    = pair_q;
    cnt_d     = cnt_q;
    ch_d      = ch_q;
    buf_we    = 1'b0;
    buf_re    = 1'b0;
    frm_we    = 1'b0;
    frm_re    = 1'b0;
    frm_waddr = '0;
    frm_wdata = '0;
    emit_o    = '0;
    case (state_q)
      rfts_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (op)
            rfts_pkg::OP_BYTE: begin
              wbuf_d = wb_sel;
              buf_we = room;
              wcnt_d = wcnt_inc;
              if (payload_end_i) begin
                len_d[wb_sel] = wcnt_inc;
                wcnt_d        = '0;
              end
            end
            rfts_pkg::OP_TICK: begin
              ms_d = (ms_q == '1) ? ms_q : (ms_q + MS_W'(1));
              if (tick_live) begin
                if (fire) begin
                  bms_d = '0;
                  if (sent_inc >= cfg_i.burst_count) begin
                    run_d  = 1'b0;
                    sent_d = '0;
                  end else begin
                    sent_d = sent_inc;
                  end
                  ch_d  = cfg_i.hop_channel[hop_q];
                  hop_d = (hop_q == HOP_W'(rfts_pkg::HOP_ENTRIES - 1)) ? '0
                                                                      : (hop_q + HOP_W'(1));
                  ms_d  = '0;
                  cnt_d = '0;
                end else begin
                  bms_d = bms_inc;
                end
              end
            end
            rfts_pkg::OP_PAIR: pair_d = 1'b1;
            default: ;
          endcase
        end
      end
      rfts_pkg::ST_SCHED: begin
        if (send_now) begin
          cnt_d   = '0;
          phase_d = (phase_q == rfts_pkg::PH_IDLE) ? rfts_pkg::PH_FIRST
                                                   : rfts_pkg::PH_SECOND;
          ms_d    = '0;
          if (cfg_i.burst_mode) begin
            frm_we    = 1'b1;
            frm_wdata = seq_q;
            flen_d    = FL_W'(cur_len) + FL_W'(1);
            run_d     = 1'b1;
            if (!run_q) begin
              bms_d  = '0;
              sent_d = '0;
            end
            if (active_q != last_q) begin
              seq_d  = seq_q + BYTE_W'(1);
              last_d = active_q;
            end
          end
        end else if (retire_now) begin
          len_d[active_q] = '0;
          active_d        = ~active_q;
          phase_d         = rfts_pkg::PH_IDLE;
          pair_d          = 1'b0;
        end
      end
      rfts_pkg::ST_COPY_RD: buf_re = 1'b1;
      rfts_pkg::ST_COPY_WR: begin
        frm_we    = 1'b1;
        frm_waddr = FA_W'(cnt_nx);
        frm_wdata = buf_rdata;
        cnt_d     = cnt_nx;
      end
      rfts_pkg::ST_DBL_RD: buf_re = 1'b1;
      rfts_pkg::ST_DBL_HI: begin
        emit_o.valid   = 1'b1;
        emit_o.data    = rfts_pkg::double_nibble(buf_rdata[7:4]);
        emit_o.last    = 1'b0;
        emit_o.channel = cfg_i.fixed_channel;
        emit_o.pair    = pair_q;
      end
      rfts_pkg::ST_DBL_LO: begin
        emit_o.valid   = 1'b1;
        emit_o.data    = rfts_pkg::double_nibble(buf_rdata[3:0]);
        emit_o.last    = cnt_last_len;
        emit_o.channel = cfg_i.fixed_channel;
        emit_o.pair    = pair_q;
        if (emit_ready_i) begin
          cnt_d = cnt_nx;
        end
      end
      rfts_pkg::ST_BURST_RD: frm_re = 1'b1;
      rfts_pkg::ST_BURST_OUT: begin
        emit_o.valid   = 1'b1;
        emit_o.data    = frm_rdata;
        emit_o.last    = cnt_last_flen;
        emit_o.channel = ch_q;
        emit_o.pair    = pair_q;
        if (emit_ready_i) begin
          cnt_d = cnt_nx;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rfts_pkg::ST_IDLE;
      len_q    <= '{default: '0};
      active_q <= 1'b0;
      wbuf_q   <= 1'b0;
      wcnt_q   <= '0;
      phase_q  <= rfts_pkg::PH_IDLE;
      ms_q     <= '0;
      flen_q   <= '0;
      seq_q    <= '0;
      last_q   <= 1'b0;
      run_q    <= 1'b0;
      sent_q   <= '0;
      bms_q    <= '0;
      hop_q    <= '0;
      pair_q   <= 1'b0;
      cnt_q    <= '0;
      ch_q     <= '0;
    end else begin
      state_q  <= state_d;
      len_q    <= len_d;
      active_q <= active_d;
      wbuf_q   <= wbuf_d;
      wcnt_q   <= wcnt_d;
      phase_q  <= phase_d;
      ms_q     <= ms_d;
      flen_q   <= flen_d;
      seq_q    <= seq_d;
      last_q   <= last_d;
      run_q    <= run_d;
      sent_q   <= sent_d;
      bms_q    <= bms_d;
      hop_q    <= hop_d;
      pair_q   <= pair_d;
      cnt_q    <= cnt_d;
      ch_q     <= ch_d;
    end
  end

endmodule

// ===== sim/tx_sequence_checker.sv =====
`timescale 1ns / 100ps
// Checker for repeat_frame_tx_sequencer_top: mirrors APB register writes, predicts the
// tx bytes of every accepted request and compares each accepted tx byte with the oldest due.
// Depends on rfts_pkg.
module tx_sequence_checker
  import rfts_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_o,
  input  logic [OP_W-1:0]    operation_i,
  input  logic [BYTE_W-1:0]  payload_byte_i,
  input  logic               payload_end_i,
  input  logic               out_valid_o,
  input  logic               out_stall_i,
  input  logic [BYTE_W-1:0]  tx_byte_o,
  input  logic               tx_end_o,
  input  logic [CH_W-1:0]    tx_channel_o,
  input  logic               use_pair_address_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic [CH_W-1:0]   channel;
    logic              pair;
  } tx_beat_t;

  tx_beat_t tx_due[$];

  logic              burst_mode;
  logic [CH_W-1:0]   hop_table [HOP_ENTRIES];
  logic [CH_W-1:0]   fixed_ch;
  logic [BCNT_W-1:0] burst_total;
  logic [BMS_W-1:0]  burst_gap;

  logic [BYTE_W-1:0] msg_store [2*BUFFER_BYTES];
  logic [5:0]        msg_len [2];
  logic              act_buf;
  logic              wr_buf;
  logic [5:0]        wr_cnt;
  phase_e            send_ph;
  logic [MS_W-1:0]   ms_elapsed;
  logic [BYTE_W-1:0] frame_bytes [BUFFER_BYTES+1];
  logic [5:0]        frame_len;
  logic [BYTE_W-1:0] seq_count;
  logic              seq_buf;
  logic              burst_on;
  logic [BCNT_W-1:0] burst_done;
  logic [BMS_W-1:0]  burst_timer;
  logic [HOP_W-1:0]  hop_idx;
  logic              pair_on;

  function automatic void reset_model();
    burst_mode  = 1'b1;
    for (int i = 0; i < HOP_ENTRIES; i++) hop_table[i] = '0;
    fixed_ch    = '0;
    burst_total = 4'd3;
    burst_gap   = 5'd6;
    msg_len[0]  = '0;
    msg_len[1]  = '0;
    act_buf     = 1'b0;
    wr_buf      = 1'b0;
    wr_cnt      = '0;
    send_ph     = PH_IDLE;
    ms_elapsed  = '0;
    frame_len   = '0;
    seq_count   = '0;
    seq_buf     = 1'b0;
    burst_on    = 1'b0;
    burst_done  = '0;
    burst_timer = '0;
    hop_idx     = '0;
    pair_on     = 1'b0;
    tx_due.delete();
  endfunction

  function automatic logic [BYTE_W-1:0] spread_nibble(input logic [3:0] n);
    logic [BYTE_W-1:0] r;
    for (int k = 0; k < 4; k++) r[2*k +: 2] = {2{n[k]}};
    return r;
  endfunction

  function automatic void queue_beat(input logic [BYTE_W-1:0] b, input logic last,
                                     input logic [CH_W-1:0] ch);
    tx_beat_t beat;
    beat.data    = b;
    beat.last    = last;
    beat.channel = ch;
    beat.pair    = pair_on;
    tx_due.push_back(beat);
  endfunction

  function automatic void load_packet();
    logic              a;
    int                len;
    logic [BYTE_W-1:0] b;
    a   = act_buf;
    len = msg_len[a];
    if (burst_mode) begin
      frame_bytes[0] = seq_count;
      for (int i = 0; i < len; i++) frame_bytes[i+1] = msg_store[int'(a)*BUFFER_BYTES + i];
      frame_len = len + 1;
      if (!burst_on) begin
        burst_timer = '0;
        burst_done  = '0;
      end
      burst_on = 1'b1;
      if (a != seq_buf) begin
        seq_count = seq_count + 1'b1;
        seq_buf   = a;
      end
    end else begin
      for (int i = 0; i < len; i++) begin
        b = msg_store[int'(a)*BUFFER_BYTES + i];
        queue_beat(spread_nibble(b[7:4]), 1'b0, fixed_ch);
        queue_beat(spread_nibble(b[3:0]), i == len - 1, fixed_ch);
      end
    end
  endfunction

  function automatic void run_schedule();
    logic a;
    while (1'b1) begin
      a = act_buf;
      if (msg_len[a] == 0) return;
      case (send_ph)
        PH_IDLE: begin
          load_packet();
          send_ph    = PH_FIRST;
          ms_elapsed = '0;
          return;
        end
        PH_FIRST: begin
          if (ms_elapsed > SECOND_SEND_MS) begin
            load_packet();
            send_ph    = PH_SECOND;
            ms_elapsed = '0;
          end
          return;
        end
        default: begin
          if (ms_elapsed <= RETIRE_MS) return;
          msg_len[a] = '0;
          act_buf    = ~a;
          send_ph    = PH_IDLE;
          pair_on    = 1'b0;
        end
      endcase
    end
  endfunction

  function automatic void burst_step();
    logic [CH_W-1:0] ch;
    if (!burst_on || !burst_mode) return;
    burst_timer = burst_timer + 1'b1;
    if (burst_gap != 0 && burst_timer < burst_gap) return;
    burst_timer = '0;
    burst_done  = burst_done + 1'b1;
    if (burst_done >= burst_total) begin
      burst_on   = 1'b0;
      burst_done = '0;
    end
    ch = hop_table[hop_idx];
    for (int i = 0; i < frame_len && i < BUFFER_BYTES + 1; i++)
      queue_beat(frame_bytes[i], i + 1 == frame_len, ch);
    hop_idx    = (hop_idx + 1) % HOP_ENTRIES;
    ms_elapsed = '0;
  endfunction

  function automatic void predict_request(input logic [OP_W-1:0] op,
                                          input logic [BYTE_W-1:0] b, input logic e);
    case (op)
      OP_BYTE: begin
        if (wr_cnt == 0) wr_buf = (send_ph == PH_IDLE) ? act_buf : ~act_buf;
        if (wr_cnt < BUFFER_BYTES) begin
          msg_store[int'(wr_buf)*BUFFER_BYTES + int'(wr_cnt)] = b;
          wr_cnt = wr_cnt + 1'b1;
        end
        if (e) begin
          msg_len[wr_buf] = wr_cnt;
          wr_cnt          = '0;
        end
      end
      OP_TICK: begin
        if (ms_elapsed != '1) ms_elapsed = ms_elapsed + 1'b1;
        burst_step();
      end
      OP_PAIR: pair_on = 1'b1;
      default: ;
    endcase
    run_schedule();
  endfunction

  function automatic void apply_write(input logic [PADDR_W-1:0] addr,
                                      input logic [PDATA_W-1:0] v);
    case (reg_e'(addr[PADDR_W-1:2]))
      REG_BURST_MODE:   burst_mode   = v[0];
      REG_HOP_A:        hop_table[0] = v[CH_W-1:0];
      REG_HOP_B:        hop_table[1] = v[CH_W-1:0];
      REG_HOP_C:        hop_table[2] = v[CH_W-1:0];
      REG_HOP_D:        hop_table[3] = v[CH_W-1:0];
      REG_FIXED_CH:     fixed_ch     = v[CH_W-1:0];
      REG_BURST_COUNT:  burst_total  = v[BCNT_W-1:0];
      REG_BURST_PERIOD: burst_gap    = v[BMS_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [BYTE_W-1:0] want,
                                      input logic [BYTE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void check_beat();
    tx_beat_t want;
    if (tx_due.size() == 0) begin
      $error("tx_byte: expected none, actual %0h", tx_byte_o);
      fail_count++;
      return;
    end
    want = tx_due.pop_front();
    check_field("tx_byte", want.data, tx_byte_o);
    check_field("tx_end", want.last, tx_end_o);
    check_field("tx_channel", want.channel, tx_channel_o);
    check_field("use_pair_address", want.pair, use_pair_address_o);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_model();
      fail_count = 0;
      pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready) apply_write(paddr, pwdata);
      if (out_valid_o && !out_stall_i) check_beat();
      if (in_valid_i && !in_stall_o) predict_request(operation_i, payload_byte_i, payload_end_i);
      pending <= tx_due.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Top-level testbench for repeat_frame_tx_sequencer_top: clock, reset, APB register
// phases and request stimulus with random idling. Depends on rfts_pkg and tx_sequence_checker.
module tb;
  import rfts_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int REG_COUNT          = 8;
  localparam int PHASES             = 6;
  localparam int REQUESTS_PER_PHASE = 20;
  localparam int SETTLE_CYCLES      = 200;
  localparam int HOLD_CYCLES        = 600;
  localparam int LIMIT_CYCLES       = 4_000_000;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               in_valid_i     = 1'b0;
  logic               in_stall_o;
  logic [OP_W-1:0]    operation_i    = OP_TICK;
  logic [BYTE_W-1:0]  payload_byte_i = '0;
  logic               payload_end_i  = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i    = 1'b0;
  logic [BYTE_W-1:0]  tx_byte_o;
  logic               tx_end_o;
  logic [CH_W-1:0]    tx_channel_o;
  logic               use_pair_address_o;
  logic               psel           = 1'b0;
  logic               penable        = 1'b0;
  logic               pwrite         = 1'b0;
  logic [PADDR_W-1:0] paddr          = '0;
  logic [PDATA_W-1:0] pwdata         = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int fail_count;
  int pending;
  int send_idle_pct = 8;
  int recv_idle_pct = 74;
  int hold_ask      = 0;
  int hold_seen     = 0;
  int requests_sent = 0;
  int cycle_count   = 0;

  repeat_frame_tx_sequencer_top dut (.*);

  tx_sequence_checker checker_i (.*);

  always #5 clk_i = ~clk_i;

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("repeat_frame_tx_sequencer_top: mismatch");
    $finish;
  end

  // receiver: random stall, or a long hold when asked
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  task automatic put_request(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] b,
                             input logic e);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    payload_byte_i <= b;
    payload_end_i  <= e;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    requests_sent++;
  endtask

  task automatic send_message(input int len, input logic closed);
    for (int i = 0; i < len; i++)
      put_request(OP_BYTE, $urandom_range(0, 255), closed && (i == len - 1));
  endtask

  task automatic tick_run(input int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)
        put_request(OP_PAIR, $urandom_range(0, 255), $urandom_range(0, 1));
      else if (pick == 1)
        put_request(OP_UNUSED, $urandom_range(0, 255), $urandom_range(0, 1));
      else
        put_request(OP_TICK, $urandom_range(0, 255), $urandom_range(0, 1));
    end
  endtask

  task automatic run_scenario();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    if (pick < 20) put_request(OP_PAIR, $urandom_range(0, 255), $urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    len  = (pick < 5) ? $urandom_range(BUFFER_BYTES + 1, BUFFER_BYTES + 4)
                      : $urandom_range(1, 6);
    send_message(len, $urandom_range(0, 19) != 0);
    tick_run($urandom_range(0, 12));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic program_registers(input int ph);
    logic [PDATA_W-1:0] val [REG_COUNT];
    for (int r = 0; r < REG_COUNT; r++) val[r] = $urandom_range(0, 83);
    val[REG_BURST_MODE]   = $urandom_range(0, 1);
    val[REG_BURST_COUNT]  = $urandom_range(1, 15);
    val[REG_BURST_PERIOD] = $urandom_range(1, 31);
    case (ph)
      0: begin
        val[REG_BURST_MODE]   = 1;
        val[REG_HOP_A]        = 0;
        val[REG_HOP_B]        = 83;
        val[REG_HOP_C]        = 41;
        val[REG_HOP_D]        = 7;
        val[REG_FIXED_CH]     = 0;
        val[REG_BURST_COUNT]  = 15;
        val[REG_BURST_PERIOD] = 1;
      end
      1: begin
        val[REG_BURST_MODE]   = 0;
        val[REG_FIXED_CH]     = 83;
        val[REG_BURST_COUNT]  = 1;
        val[REG_BURST_PERIOD] = 31;
      end
      2: begin
        val[REG_BURST_MODE]   = 1;
        val[REG_BURST_COUNT]  = 1;
        val[REG_BURST_PERIOD] = 31;
      end
      3: begin
        val[REG_BURST_MODE]   = 0;
        val[REG_HOP_A]        = 83;
        val[REG_HOP_B]        = 83;
        val[REG_HOP_C]        = 0;
        val[REG_HOP_D]        = 0;
        val[REG_FIXED_CH]     = 0;
        val[REG_BURST_COUNT]  = 15;
        val[REG_BURST_PERIOD] = 1;
      end
      4: val[REG_BURST_MODE] = 1;
      default: ;
    endcase
    for (int r = 0; r < REG_COUNT; r++) begin
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {reg_e'(r), 2'b00};
      pwdata  <= val[r];
      @(posedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
      while (!pready) @(posedge clk_i);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int phase_stop;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset registers: burst mode, three sends six ms apart; receiver holds off
    hold_ask++;
    put_request(OP_PAIR, 8'h00, 1'b0);
    put_request(OP_BYTE, 8'h00, 1'b0);
    put_request(OP_BYTE, 8'h80, 1'b0);
    put_request(OP_BYTE, 8'hFF, 1'b1);
    put_request(OP_UNUSED, 8'hFF, 1'b1);
    // sender busy: lands in the other buffer
    put_request(OP_BYTE, 8'h5A, 1'b1);
    repeat (12) put_request(OP_TICK, 8'hA5, 1'b0);
    put_request(OP_TICK, 8'h00, 1'b1);
    put_request(OP_TICK, 8'hFF, 1'b1);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clk_i);
      program_registers(ph);
      send_idle_pct = (ph < 2) ? 8 : (ph < 4) ? 74 : 0;
      recv_idle_pct = (ph < 2) ? 74 : (ph < 4) ? 8 : 0;
      phase_stop = requests_sent + REQUESTS_PER_PHASE;
      if (ph == 1) begin
        hold_ask++;
        send_message(BUFFER_BYTES, 1'b1);
      end
      if (ph == 2) begin
        run_scenario();
        wait_drained();
      end
      if (ph == 3) begin
        send_message(3, 1'b1);
        repeat (SECOND_SEND_MS + 1) put_request(OP_TICK, 8'h00, 1'b0);
      end
      while (requests_sent < phase_stop) run_scenario();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0)
      $display("repeat_frame_tx_sequencer_top: match");
    else
      $display("repeat_frame_tx_sequencer_top: mismatch");
    $finish;
  end

endmodule
